### rtl/first_fit_bin_packing_assert.svh
// Assertion helpers for the bin packer; clocked on clk, off while rst is high.
`ifndef FIRST_FIT_BIN_PACKING_ASSERT_SVH
`define FIRST_FIT_BIN_PACKING_ASSERT_SVH

// same-cycle implication
`define FFBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffbp assertion failed");

// next-cycle implication
`define FFBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffbp assertion failed");

`endif

### rtl/ffbp_pkg.sv
package ffbp_pkg;

  // fixed widths of the port fields
  localparam int FIELD_W = 16;
  localparam int NUM_W   = 9;

  typedef struct packed {
    logic [NUM_W-1:0] bin_number;
    logic [NUM_W-1:0] bins_used;
    logic             oversize;
    logic             no_free_bin;
    logic             set_done;
  } res_t;

endpackage

### rtl/ffbp_load_mem.sv
module ffbp_load_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ffbp_scan.sv
module ffbp_scan #(
  parameter int MAX_BINS    = 256,
  parameter int VOLUME_BITS = 16,
  parameter int IDX_W       = 8,
  parameter int CNT_W       = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VOLUME_BITS-1:0] vol,
  input  logic                   last,
  input  logic [VOLUME_BITS-1:0] cap,
  output logic                   idle,
  output ffbp_pkg::res_t         res,
  output logic                   res_valid,
  input  logic                   res_take,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  input  logic [VOLUME_BITS-1:0] rd_data,
  output logic                   wr_en,
  output logic [IDX_W-1:0]       wr_addr,
  output logic [VOLUME_BITS-1:0] wr_data
);
  import ffbp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OPEN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]             state;
  logic [IDX_W-1:0]       chk;
  logic [CNT_W-1:0]       count;
  logic [VOLUME_BITS-1:0] vol_q;
  logic                   last_q;
  logic                   ovs_q;

  logic [VOLUME_BITS:0]   sum;
  logic                   fit;
  logic                   last_chk;
  logic                   has_free;
  logic [31:0]            chk_p1_ext;
  logic [31:0]            cnt_ext;
  logic [31:0]            cnt_p1_ext;

  assign sum        = {1'b0, rd_data} + {1'b0, vol_q};
  assign fit        = sum <= {1'b0, cap};
  assign last_chk   = (CNT_W'(chk) + CNT_W'(1)) == count;
  assign has_free   = count < CNT_W'(MAX_BINS);
  assign chk_p1_ext = 32'(chk) + 32'd1;
  assign cnt_ext    = 32'(count);
  assign cnt_p1_ext = 32'(count) + 32'd1;

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_FIN;

  // memory accesses: one read per scanned bin, one write when the item lands
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = chk;
    wr_data = sum[VOLUME_BITS-1:0];
    case (state)
      S_IDLE: begin
        rd_en = start && (count != '0);
      end
      S_SCAN: begin
        if (fit) begin
          wr_en = 1'b1;
        end else if (!last_chk) begin
          rd_en   = 1'b1;
          rd_addr = IDX_W'(chk_p1_ext);
        end
      end
      S_OPEN: begin
        wr_en   = has_free;
        wr_addr = count[IDX_W-1:0];
        wr_data = vol_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            vol_q  <= vol;
            last_q <= last;
            ovs_q  <= vol > cap;
            chk    <= '0;
            state  <= (count == '0) ? S_OPEN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (fit) begin
            res.bin_number  <= chk_p1_ext[NUM_W-1:0];
            res.bins_used   <= cnt_ext[NUM_W-1:0];
            res.oversize    <= ovs_q;
            res.no_free_bin <= 1'b0;
            res.set_done    <= last_q;
            if (last_q) begin
              count <= '0;
            end
            state <= S_FIN;
          end else if (last_chk) begin
            state <= S_OPEN;
          end else begin
            chk <= IDX_W'(chk_p1_ext);
          end
        end
        S_OPEN: begin
          res.oversize <= ovs_q;
          res.set_done <= last_q;
          if (has_free) begin
            res.bin_number  <= cnt_p1_ext[NUM_W-1:0];
            res.bins_used   <= cnt_p1_ext[NUM_W-1:0];
            res.no_free_bin <= 1'b0;
            count           <= last_q ? '0 : CNT_W'(cnt_p1_ext);
          end else begin
            res.bin_number  <= '0;
            res.bins_used   <= cnt_ext[NUM_W-1:0];
            res.no_free_bin <= 1'b1;
            if (last_q) begin
              count <= '0;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/first_fit_bin_packing.sv
// Order: an item that lands in open bin k has its result after bins 1..k are
//   scanned; one that opens a new bin (or finds none) scans every open bin first.
// Throughput: one item at a time, set by the scan of the load memory, one bin
//   read per cycle through its single read port.
// Reset (rst, sync, high): no open bins, capacity back to 'hffff (all ones for
//   VOLUME_BITS up to 16), output empty; the load memory is not cleared and is only read once written.
module first_fit_bin_packing #(
  parameter int MAX_BINS    = 256,
  parameter int VOLUME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: bin capacity
  input  logic                          cfg_we,
  input  logic [ffbp_pkg::FIELD_W-1:0]  cfg_wdata,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffbp_pkg::FIELD_W-1:0]  item_volume,
  input  logic                          last_item,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffbp_pkg::NUM_W-1:0]    bin_number,
  output logic [ffbp_pkg::NUM_W-1:0]    bins_used,
  output logic                          oversize,
  output logic                          no_free_bin,
  output logic                          set_done
);
  import ffbp_pkg::*;

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);

  logic [VOLUME_BITS-1:0] cap;
  logic [31:0]            cfg_ext;
  logic [31:0]            vol_ext;
  logic [VOLUME_BITS-1:0] vol;

  logic                   idle;
  logic                   start;
  res_t                   res;
  logic                   res_valid;
  logic                   res_take;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [VOLUME_BITS-1:0] rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [VOLUME_BITS-1:0] wr_data;

  // volumes and capacity are taken at VOLUME_BITS: zero-extend or truncate
  assign cfg_ext = 32'(cfg_wdata);
  assign vol_ext = 32'(item_volume);
  assign vol     = vol_ext[VOLUME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= VOLUME_BITS'(32'h0000_ffff);
    end else if (cfg_we) begin
      cap <= cfg_ext[VOLUME_BITS-1:0];
    end
  end

  // only one item in the scanner at a time; the output register lets the
  // next item start while the previous result waits downstream
  assign in_stall = !idle;
  assign start    = in_valid && idle;

  ffbp_scan #(
    .MAX_BINS    (MAX_BINS),
    .VOLUME_BITS (VOLUME_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .vol       (vol),
    .last      (last_item),
    .cap       (cap),
    .idle      (idle),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // bin loads; writes and reads of one item never overlap the next item's
  ffbp_load_mem #(
    .DEPTH  (MAX_BINS),
    .ADDR_W (IDX_W),
    .DATA_W (VOLUME_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      bin_number  <= res.bin_number;
      bins_used   <= res.bins_used;
      oversize    <= res.oversize;
      no_free_bin <= res.no_free_bin;
      set_done    <= res.set_done;
    end
  end

endmodule

### rtl/ffbp_check.sv
`include "first_fit_bin_packing_assert.svh"

module ffbp_check #(
  parameter int MAX_BINS = 256
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ffbp_pkg::NUM_W-1:0] bin_number,
  input logic [ffbp_pkg::NUM_W-1:0] bins_used,
  input logic                       no_free_bin
);
  import ffbp_pkg::*;

  localparam bit NUM_FITS = MAX_BINS < (1 << NUM_W);

  // a held result stays offered
  `FFBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // the scanner is busy in the cycle after it accepts an item
  `FFBP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a dropped item names no bin
  `FFBP_ASSERT_NOW(a_drop_no_bin, out_valid && no_free_bin, bin_number == '0)
  // the chosen bin is one of the open ones; bin 0 only on a drop
  `FFBP_ASSERT_NOW(a_bin_in_range, out_valid && NUM_FITS,
                   (bin_number <= bins_used) && ((bin_number != '0) || no_free_bin))

endmodule

bind first_fit_bin_packing ffbp_check #(.MAX_BINS(MAX_BINS)) u_ffbp_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bin_number  (bin_number),
  .bins_used   (bins_used),
  .no_free_bin (no_free_bin)
);
